/* src/rsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary sine/cosine generator package
// Shared constants, cell coefficient functions and code types.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int F_BITS      = 28;
	localparam int K_BITS      = 11;
	localparam int E_BITS      = F_BITS + K_BITS;
	localparam int EXP_CELLS   = 28;
	localparam int SIN_CELLS   = 4;
	localparam int COS_CELLS   = 5;

	localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
	localparam logic [31:0] HALF_Q32   = 32'h8000_0000;
	localparam logic [31:0] INV2PI_HI  = 32'h28BE_60DB;
	localparam logic [31:0] INV2PI_LO  = 32'h9391_054A;
	localparam logic [34:0] TWO_PI_Q32 = 35'h6_487E_D511;

	typedef enum logic [1:0] {
		CFG_ROTARY_DIM = 2'd0,
		CFG_LOG2_STEP  = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Bitwise floor square root, evaluated at elaboration only.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r   = '0;
		rem = v;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q32 value of 2^-(2^-j); each entry is the square root of the one before.
	function automatic logic [31:0] exp_coef(input int j);
		logic [63:0] c;
		c = floor_sqrt(64'h8000_0000_0000_0000);
		for (int i = 1; i < j; i++) begin
			c = floor_sqrt({c[31:0], 32'd0});
		end
		return c[31:0];
	endfunction

	function automatic int sin_div(input int i);
		int d;
		d = 6;
		case (i)
			0:       d = 72;
			1:       d = 42;
			2:       d = 20;
			default: d = 6;
		endcase
		return d;
	endfunction

	function automatic int cos_div(input int i);
		int d;
		d = 2;
		case (i)
			0:       d = 90;
			1:       d = 56;
			2:       d = 30;
			3:       d = 12;
			default: d = 2;
		endcase
		return d;
	endfunction

endpackage

/* src/rsc_exp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponent cell
// One bit of the fractional exponent: multiplies the running 2^-f value by
// its fixed root-of-two coefficient when that bit is set.
// ----------------------------------------------------------------------------
module rsc_exp_cell #(
	parameter int J      = 1,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [32:0]       m_in,
	input  logic [27:0]       f_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [32:0]       m_out,
	output logic [27:0]       f_out,
	output logic [SIDE_W-1:0] side_out
);
	import rsc_pkg::*;

	localparam logic [31:0] COEF = exp_coef(J);

	logic [64:0]       prod;
	logic [32:0]       m_s1;
	logic [27:0]       f_s1;
	logic [SIDE_W-1:0] side_s1;

	assign prod = m_in * COEF + 65'(HALF_Q32);

	always_ff @(posedge clk) begin
		m_s1    <= f_in[F_BITS-J] ? prod[64:32] : m_in;
		f_s1    <= f_in;
		side_s1 <= side_in;
	end

	assign m_out    = m_s1;
	assign f_out    = f_s1;
	assign side_out = side_s1;

endmodule

/* src/rsc_horner_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner cell
// One Taylor step t' = 1 - (s2 * t) / D in unsigned Q32, over two stages:
// the product, then the division by D as a reciprocal multiply.
// ----------------------------------------------------------------------------
module rsc_horner_cell #(
	parameter int D      = 2,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [31:0]       s2_in,
	input  logic [32:0]       t_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [31:0]       s2_out,
	output logic [32:0]       t_out,
	output logic [SIDE_W-1:0] side_out
);
	import rsc_pkg::*;

	localparam int          SH    = 32 + $clog2(D);
	localparam logic [33:0] RECIP = 34'(((64'd1 << SH) / D) + 64'd1);

	logic [64:0]       prod;
	logic [31:0]       p_s1;
	logic [31:0]       s2_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [65:0]       qp_s2;
	logic [31:0]       s2_s2;
	logic [SIDE_W-1:0] side_s2;

	assign prod = s2_in * t_in;

	always_ff @(posedge clk) begin
		p_s1    <= prod[63:32];
		s2_s1   <= s2_in;
		side_s1 <= side_in;
		qp_s2   <= p_s1 * RECIP;
		s2_s2   <= s2_s1;
		side_s2 <= side_s1;
	end

	assign t_out    = ONE_Q32 - 33'(qp_s2 >> SH);
	assign s2_out   = s2_s2;
	assign side_out = side_s2;

endmodule

/* src/rotary_angle_sin_cos_gen_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding sine/cosine generator
// Takes a token position and a pair index and returns sine and cosine of
// the pair's rotary angle in signed fixed point.
// ----------------------------------------------------------------------------
// The unit is fully pipelined: it takes one transaction in every cycle and
// busy never rises. Each result appears on done once its transaction has
// passed the input stage, the 28-cell exponent chain, the phase and angle
// stages, the five two-stage Horner cells of the cosine series and the
// output register. The receiver cannot stall, so results must be captured
// when done is high. Configuration is always ready and must be written
// while no transaction is in flight.
module rotary_angle_sin_cos_gen_unit #(
	parameter int POSITION_BITS = 16,
	parameter int MAX_PAIRS     = 128,
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [POSITION_BITS-1:0] position,
	input  logic [6:0]               pair_index,
	output logic                     done,
	output logic [OUT_FRAC_BITS:0]   sine,
	output logic [OUT_FRAC_BITS:0]   cosine,
	output logic                     in_range,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  rsc_pkg::cfg_idx_t        cfg_index,
	input  logic [31:0]              cfg_data
);
	import rsc_pkg::*;

	localparam int LAT    = 47;
	localparam int OUT_W  = OUT_FRAC_BITS + 1;
	localparam int SHR    = 32 - OUT_FRAC_BITS;
	localparam int E_SIDE = K_BITS + POSITION_BITS + 1;
	localparam logic [33:0]      RND    = 34'(1) << (31 - OUT_FRAC_BITS);
	localparam logic [OUT_W-1:0] MAXMAG = {1'b0, {OUT_FRAC_BITS{1'b1}}};

	function automatic logic [OUT_W-1:0] to_out(input logic [32:0] v, input logic neg);
		logic [33:0]      r;
		logic [OUT_W-1:0] mag;
		r = (34'(v) + RND) >> SHR;
		if (r > 34'(MAXMAG)) begin
			mag = MAXMAG;
		end else begin
			mag = r[OUT_W-1:0];
		end
		return neg ? (~mag + 1'b1) : mag;
	endfunction

	// Configuration registers
	logic [8:0]  rotary_dim_q;
	logic [31:0] log2_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotary_dim_q <= 9'd128;
			log2_step_q  <= 32'd55732839;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROTARY_DIM: rotary_dim_q <= cfg_data[8:0];
				CFG_LOG2_STEP:  log2_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid line
	logic           accept;
	logic [LAT-1:0] vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Stage 1: range check and exponent product
	logic                     rng_c;
	logic [E_BITS-1:0]        e_c;
	logic [E_BITS-1:0]        e_s1;
	logic [POSITION_BITS-1:0] pos_s1;
	logic                     rng_s1;

	assign rng_c = (8'(pair_index) < rotary_dim_q[8:1]) && (8'(pair_index) < 8'(MAX_PAIRS));
	assign e_c   = E_BITS'(pair_index) * E_BITS'(log2_step_q);

	always_ff @(posedge clk) begin
		e_s1   <= e_c;
		pos_s1 <= position;
		rng_s1 <= rng_c;
	end

	// Exponent chain: 2^-f one fraction bit per cell
	logic [32:0]       m_w    [0:EXP_CELLS];
	logic [27:0]       f_w    [0:EXP_CELLS];
	logic [E_SIDE-1:0] eside_w[0:EXP_CELLS];

	assign m_w[0]     = ONE_Q32;
	assign f_w[0]     = e_s1[F_BITS-1:0];
	assign eside_w[0] = {e_s1[E_BITS-1:F_BITS], pos_s1, rng_s1};

	for (genvar j = 1; j <= EXP_CELLS; j++) begin : g_exp
		rsc_exp_cell #(
			.J      (j),
			.SIDE_W (E_SIDE)
		) u_cell (
			.clk      (clk),
			.m_in     (m_w[j-1]),
			.f_in     (f_w[j-1]),
			.side_in  (eside_w[j-1]),
			.m_out    (m_w[j]),
			.f_out    (f_w[j]),
			.side_out (eside_w[j])
		);
	end

	// Stages 30-33: frequency in turns, shift, times position
	logic [64:0]              ga_s30, gb_s30;
	logic [K_BITS-1:0]        k_s30;
	logic [POSITION_BITS-1:0] pos_s30;
	logic                     rng_s30;
	logic [64:0]              gsum;
	logic [63:0]              g_s31;
	logic [POSITION_BITS-1:0] pos_s31;
	logic                     rng_s31;
	logic [POSITION_BITS+31:0] plo_c, phi_c;
	logic [POSITION_BITS+31:0] plo_s32;
	logic [31:0]              phi_s32;
	logic                     rng_s32;
	logic [63:0]              phase_s33;
	logic                     rng_s33;

	assign gsum = ga_s30 + ((gb_s30 + 65'(HALF_Q32)) >> 32);
	assign plo_c = pos_s31 * g_s31[31:0];
	assign phi_c = pos_s31 * g_s31[63:32];

	always_ff @(posedge clk) begin
		ga_s30  <= m_w[EXP_CELLS] * INV2PI_HI;
		gb_s30  <= m_w[EXP_CELLS] * INV2PI_LO;
		{k_s30, pos_s30, rng_s30} <= eside_w[EXP_CELLS];

		// A shift of 64 or more leaves a zero frequency.
		if (k_s30[K_BITS-1:6] != '0) begin
			g_s31 <= '0;
		end else begin
			g_s31 <= gsum[63:0] >> k_s30[5:0];
		end
		pos_s31 <= pos_s30;
		rng_s31 <= rng_s30;

		plo_s32 <= plo_c;
		phi_s32 <= phi_c[31:0];
		rng_s32 <= rng_s31;

		phase_s33 <= {phi_s32, 32'd0} + 64'(plo_s32);
		rng_s33   <= rng_s32;
	end

	// Stages 34-36: octant fold, radians, square
	logic [61:0] uf;
	logic [64:0] xp_s34;
	logic [2:0]  oct_s34;
	logic        rng_s34;
	logic [31:0] x_s35;
	logic [2:0]  oct_s35;
	logic        rng_s35;
	logic [63:0] xsq;
	logic [31:0] x_s36, s2_s36;
	logic [2:0]  oct_s36;
	logic        rng_s36;

	// Odd octants measure the angle back from the next octant boundary.
	assign uf  = phase_s33[61] ? (62'(1) << 61) - 62'(phase_s33[60:0])
	                           : 62'(phase_s33[60:0]);
	assign xsq = x_s35 * x_s35;

	always_ff @(posedge clk) begin
		xp_s34  <= uf[61:32] * TWO_PI_Q32;
		oct_s34 <= phase_s33[63:61];
		rng_s34 <= rng_s33;

		x_s35   <= 32'((xp_s34 + 65'(HALF_Q32)) >> 32);
		oct_s35 <= oct_s34;
		rng_s35 <= rng_s34;

		s2_s36  <= xsq[63:32];
		x_s36   <= x_s35;
		oct_s36 <= oct_s35;
		rng_s36 <= rng_s35;
	end

	// Horner chains for sine and cosine
	logic [31:0] cs2_w [0:COS_CELLS];
	logic [32:0] ct_w  [0:COS_CELLS];
	logic [3:0]  cside_w[0:COS_CELLS];
	logic [31:0] ss2_w [0:SIN_CELLS];
	logic [32:0] st_w  [0:SIN_CELLS];
	logic [31:0] sx_w  [0:SIN_CELLS];

	assign cs2_w[0]   = s2_s36;
	assign ct_w[0]    = ONE_Q32;
	assign cside_w[0] = {oct_s36, rng_s36};
	assign ss2_w[0]   = s2_s36;
	assign st_w[0]    = ONE_Q32;
	assign sx_w[0]    = x_s36;

	for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos
		rsc_horner_cell #(
			.D      (cos_div(i)),
			.SIDE_W (4)
		) u_cell (
			.clk      (clk),
			.s2_in    (cs2_w[i]),
			.t_in     (ct_w[i]),
			.side_in  (cside_w[i]),
			.s2_out   (cs2_w[i+1]),
			.t_out    (ct_w[i+1]),
			.side_out (cside_w[i+1])
		);
	end

	for (genvar i = 0; i < SIN_CELLS; i++) begin : g_sin
		rsc_horner_cell #(
			.D      (sin_div(i)),
			.SIDE_W (32)
		) u_cell (
			.clk      (clk),
			.s2_in    (ss2_w[i]),
			.t_in     (st_w[i]),
			.side_in  (sx_w[i]),
			.s2_out   (ss2_w[i+1]),
			.t_out    (st_w[i+1]),
			.side_out (sx_w[i+1])
		);
	end

	// Stages 45-46: sine = x * t, aligned with the longer cosine chain
	logic [64:0] sprod;
	logic [31:0] sv_s45, sv_s46;

	assign sprod = sx_w[SIN_CELLS] * st_w[SIN_CELLS];

	always_ff @(posedge clk) begin
		sv_s45 <= sprod[63:32];
		sv_s46 <= sv_s45;
	end

	// Stage 47: octant symmetry, rounding, output register
	logic [2:0]       oct_46;
	logic             rng_46;
	logic [32:0]      sp, cp;
	logic [OUT_W-1:0] sine_c, cosine_c;
	logic [OUT_W-1:0] sine_s47, cosine_s47;
	logic             rng_s47;

	assign {oct_46, rng_46} = cside_w[COS_CELLS];
	assign sp = oct_46[0] ? ct_w[COS_CELLS] : {1'b0, sv_s46};
	assign cp = oct_46[0] ? {1'b0, sv_s46} : ct_w[COS_CELLS];

	always_comb begin
		unique case (quad_t'(oct_46[2:1]))
			QUAD_0: begin
				sine_c   = to_out(sp, 1'b0);
				cosine_c = to_out(cp, 1'b0);
			end
			QUAD_1: begin
				sine_c   = to_out(cp, 1'b0);
				cosine_c = to_out(sp, 1'b1);
			end
			QUAD_2: begin
				sine_c   = to_out(sp, 1'b1);
				cosine_c = to_out(cp, 1'b1);
			end
			default: begin
				sine_c   = to_out(cp, 1'b1);
				cosine_c = to_out(sp, 1'b0);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sine_s47   <= rng_46 ? sine_c : '0;
		cosine_s47 <= rng_46 ? cosine_c : '0;
		rng_s47    <= rng_46;
	end

	assign done     = vld_q[LAT-1];
	assign sine     = sine_s47;
	assign cosine   = cosine_s47;
	assign in_range = rng_s47;

	// Checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result missing after fixed latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching transaction");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> sine == '0 && cosine == '0)
		else $error("out-of-range pair gave nonzero output");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_range |-> sine != {1'b1, {OUT_FRAC_BITS{1'b0}}}
			&& cosine != {1'b1, {OUT_FRAC_BITS{1'b0}}})
		else $error("output magnitude beyond saturation limit");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary sine/cosine generator testbench
// Drives position and pair index transactions through several register
// settings and checks every sine, cosine and range flag against a predictor.
// ----------------------------------------------------------------------------

class rope_scoreboard;
	typedef struct packed {
		logic [15:0] sine;
		logic [15:0] cosine;
		logic        in_range;
	} trig_t;

	trig_t        pending[$];
	logic [8:0]   rotary_dim;
	logic [31:0]  log2_step;
	int           errors;

	function new();
		rotary_dim = 9'd128;
		log2_step  = 32'd55732839;
		errors     = 0;
	endfunction

	function void set_reg(rsc_pkg::cfg_idx_t idx, logic [31:0] value);
		if (idx == rsc_pkg::CFG_ROTARY_DIM)
			rotary_dim = value[8:0];
		else if (idx == rsc_pkg::CFG_LOG2_STEP)
			log2_step = value;
	endfunction

	static function logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	static function logic [63:0] sin_series(logic [63:0] x);
		logic [63:0] s2, t;
		s2 = (x * x) >> 32;
		t = 64'h1_0000_0000 - s2 / 72;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 42;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 20;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 6;
		return (x * t) >> 32;
	endfunction

	static function logic [63:0] cos_series(logic [63:0] x);
		logic [63:0] s2, t;
		s2 = (x * x) >> 32;
		t = 64'h1_0000_0000 - s2 / 90;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 56;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 30;
		t = 64'h1_0000_0000 - ((s2 * t) >> 32) / 12;
		return 64'h1_0000_0000 - ((s2 * t) >> 32) / 2;
	endfunction

	static function logic [15:0] to_q15(logic [63:0] v, bit neg);
		logic [63:0] r;
		r = (v + 64'h1_0000) >> 17;
		if (r > 64'h7FFF) r = 64'h7FFF;
		if (neg) r = -r;
		return r[15:0];
	endfunction

	function trig_t predict(logic [15:0] pos, logic [6:0] pair);
		trig_t res;
		logic [63:0] e, k, m, c, g, phase, u, x, s, co, sp, cp;
		logic [2:0] oct;
		res = '0;
		if (pair >= (rotary_dim >> 1)) return res;
		e = 64'(pair) * 64'(log2_step);
		k = e >> 28;
		m = 64'h1_0000_0000;
		c = isqrt(64'h8000_0000_0000_0000);
		for (int j = 1; j <= 28; j++) begin
			if (e[28 - j]) m = (m * c + 64'h8000_0000) >> 32;
			c = isqrt(c << 32);
		end
		g = m * 64'h28BE60DB + ((m * 64'h9391054A + 64'h8000_0000) >> 32);
		g = (k < 64) ? (g >> k) : 64'd0;
		phase = 64'(pos) * g;
		oct = phase[63:61];
		u = {3'b0, phase[60:0]};
		if (oct[0]) u = (64'd1 << 61) - u;
		x = ((u >> 32) * 64'h6487ED511 + 64'h8000_0000) >> 32;
		s = sin_series(x);
		co = cos_series(x);
		sp = oct[0] ? co : s;
		cp = oct[0] ? s : co;
		case (rsc_pkg::quad_t'(oct[2:1]))
			rsc_pkg::QUAD_0: begin res.sine = to_q15(sp, 0); res.cosine = to_q15(cp, 0); end
			rsc_pkg::QUAD_1: begin res.sine = to_q15(cp, 0); res.cosine = to_q15(sp, 1); end
			rsc_pkg::QUAD_2: begin res.sine = to_q15(sp, 1); res.cosine = to_q15(cp, 1); end
			default:         begin res.sine = to_q15(cp, 1); res.cosine = to_q15(sp, 0); end
		endcase
		res.in_range = 1'b1;
		return res;
	endfunction

	function void note_input(logic [15:0] pos, logic [6:0] pair);
		pending.insert(pending.size(), predict(pos, pair));
	endfunction

	function void report(string what);
		$display("mismatch: %s", what);
		errors++;
	endfunction

	function void check_result(logic [15:0] sn, logic [15:0] cs, logic ir);
		trig_t want;
		if (pending.size() == 0) begin
			report("result with no transaction outstanding");
			return;
		end
		want = pending.pop_front();
		if (sn !== want.sine)
			report($sformatf("sine %h expected %h", sn, want.sine));
		if (cs !== want.cosine)
			report($sformatf("cosine %h expected %h", cs, want.cosine));
		if (ir !== want.in_range)
			report($sformatf("in_range %b expected %b", ir, want.in_range));
	endfunction
endclass

module tb_top;
	localparam int LATENCY = 47;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk, arst_n, start, busy, done, in_range, cfg_valid, cfg_ready;
	logic [15:0] position, sine, cosine;
	logic [6:0] pair_index;
	rsc_pkg::cfg_idx_t cfg_index;
	logic [31:0] cfg_data;

	rope_scoreboard angles;
	int idle_cycles;
	bit quiet_stretch;

	rotary_angle_sin_cos_gen_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.position(position), .pair_index(pair_index), .done(done),
		.sine(sine), .cosine(cosine), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Results are sampled at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			angles.check_result(sine, cosine, in_range);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL rotary_angle_sin_cos_gen_unit");
			$finish;
		end
	end

	task automatic drain();
		while (angles.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers change only once every outstanding transaction has come back.
	task automatic write_reg(rsc_pkg::cfg_idx_t idx, logic [31:0] value);
		start <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		angles.set_reg(idx, value);
		cfg_valid <= 1'b0;
	endtask

	// Issues one transaction; the next call may keep start high without a gap.
	task automatic send(logic [15:0] pos, logic [6:0] pair);
		while (!quiet_stretch && $urandom_range(99) < 7) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		position   <= pos;
		pair_index <= pair;
		@(posedge clk);
		while (busy) @(posedge clk);
		angles.note_input(pos, pair);
	endtask

	task automatic random_burst(int count);
		logic [6:0] lim;
		for (int n = 0; n < count; n++) begin
			quiet_stretch = (n >= count / 3) && (n < count / 2);
			lim = (angles.rotary_dim >> 1) > 1 ? 7'((angles.rotary_dim >> 1) - 1) : 7'd0;
			if ($urandom_range(9) < 8)
				send(16'($urandom), 7'($urandom_range(lim)));
			else
				send(16'($urandom), 7'($urandom));
		end
		quiet_stretch = 0;
		start <= 1'b0;
		@(posedge clk);
		drain();
	endtask

	initial begin
		angles = new();
		idle_cycles = 0;
		quiet_stretch = 0;
		arst_n = 1'b0;
		start = 1'b0;
		position = '0;
		pair_index = '0;
		cfg_valid = 1'b0;
		cfg_index = rsc_pkg::CFG_ROTARY_DIM;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes, zero angle, out of range.
		send(16'd0, 7'd0);
		send(16'hFFFF, 7'd0);
		send(16'd1, 7'd0);
		send(16'hFFFF, 7'd63);
		send(16'hFFFF, 7'd64);
		send(16'hFFFF, 7'd127);
		send(16'h1234, 7'd1);
		send(16'd3, 7'd2);
		send(16'hAAAA, 7'h55);
		send(16'h5555, 7'h2A);
		start <= 1'b0;
		@(posedge clk);
		drain();

		// Largest table, zero step: same frequency for every pair.
		write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'd256);
		write_reg(rsc_pkg::CFG_LOG2_STEP, 32'd0);
		send(16'hFFFF, 7'd127);
		send(16'd1, 7'd127);
		send(16'd25736, 7'd5);
		random_burst(90);

		// Huge step: for larger pair indices the shift reaches 64 and the angle collapses to zero.
		write_reg(rsc_pkg::CFG_LOG2_STEP, 32'hFFFF_FFFF);
		send(16'hFFFF, 7'd127);
		send(16'hFFFF, 7'd1);
		random_burst(60);

		// Odd and tiny dimensions.
		write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'd3);
		write_reg(rsc_pkg::CFG_LOG2_STEP, 32'h0123_4567);
		send(16'h7FFF, 7'd0);
		send(16'h7FFF, 7'd1);
		write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'd1);
		send(16'h7FFF, 7'd0);
		write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'd0);
		send(16'h7FFF, 7'd0);
		start <= 1'b0;
		@(posedge clk);
		drain();

		write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'd2);
		random_burst(40);

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(rsc_pkg::CFG_ROTARY_DIM, 32'($urandom_range(2, 256)));
			write_reg(rsc_pkg::CFG_LOG2_STEP,
				ph[0] ? 32'($urandom) : 32'($urandom_range(0, 32'h0800_0000)));
			random_burst(85);
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (angles.errors == 0 && angles.pending.size() == 0)
			$display("PASS rotary_angle_sin_cos_gen_unit");
		else
			$display("FAIL rotary_angle_sin_cos_gen_unit");
		$finish;
	end
endmodule
